// ===== rtl/core/spa_pkg.sv =====
// spa_pkg: shared constants, types and helpers of the slot pool allocator
// no dependencies; imported by every module of the block
`default_nettype none

package spa_pkg;

	localparam int SLOTS     = 512;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int LINK_W    = $clog2(SLOTS + 1);
	localparam int SLOT_IO_W = 9;
	localparam int CMP_W     = SLOT_IO_W + LINK_W;
	localparam int TDATA_W   = ((SLOT_IO_W + 7) / 8) * 8;
	localparam int TUSER_M_W = 2;

	// link code meaning no slot
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

	localparam logic FUNC_ALLOC      = 1'b0;
	localparam logic FUNC_FREE       = 1'b1;
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_INACTIVE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REL_CHK,
		S_REL_W2,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_ALLOC_W2,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RA_IN_SLOT,
		RA_FREE_HEAD,
		RA_OLDEST
	} rd_sel_t;

	typedef struct packed {
		logic    accept;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    rel_w1;
		logic    rel_w2;
		logic    alc_w1;
		logic    alc_w2;
		logic    out_load;
		logic    res_guard;
		logic    res_echo;
		logic    res_reclaimed;
		logic    res_status;
	} cmd_t;

	typedef struct packed {
		logic rd_active;
		logic free_empty;
		logic oldest_none;
	} stat_t;

	function automatic logic link_valid(input logic [LINK_W-1:0] l);
		return l < LINK_W'(SLOTS);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spa_ctrl.sv =====
// spa_ctrl: sequencer of the slot pool allocator
// depends on spa_pkg; drives the datapath through cmd_t, reads stat_t
`default_nettype none

module spa_ctrl import spa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  s_func,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q, state_d;
	logic   free_op_q, free_op_d;
	logic   reclaim_q, reclaim_d;
	logic   bad_q, bad_d;
	logic   guard_q, guard_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_op_q   <= 1'b0;
			reclaim_q   <= 1'b0;
			bad_q       <= 1'b0;
			guard_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			free_op_q <= free_op_d;
			reclaim_q <= reclaim_d;
			bad_q     <= bad_d;
			guard_q   <= guard_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		free_op_d = free_op_q;
		reclaim_d = reclaim_q;
		bad_d     = bad_q;
		guard_d   = guard_q;
		s_tready  = 1'b0;
		cmd       = '0;
		cmd.rd_sel        = RA_FREE_HEAD;
		cmd.res_guard     = guard_q;
		cmd.res_echo      = free_op_q;
		cmd.res_reclaimed = reclaim_q;
		cmd.res_status    = bad_q ? STATUS_INACTIVE : STATUS_OK;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					cmd.rd_en  = 1'b1;
					free_op_d  = (s_func == FUNC_FREE);
					reclaim_d  = 1'b0;
					bad_d      = 1'b0;
					guard_d    = 1'b0;
					if (s_func == FUNC_FREE) begin
						cmd.rd_sel = RA_IN_SLOT;
						state_d    = S_REL_CHK;
					end else begin
						cmd.rd_sel = RA_FREE_HEAD;
						state_d    = S_ALLOC_CHK;
					end
				end
			end
			S_REL_CHK: begin
				if (stat.rd_active) begin
					cmd.rel_w1 = 1'b1;
					state_d    = S_REL_W2;
				end else begin
					bad_d   = 1'b1;
					state_d = S_DONE;
				end
			end
			S_REL_W2: begin
				cmd.rel_w2 = 1'b1;
				state_d    = reclaim_q ? S_ALLOC_RD : S_DONE;
			end
			S_ALLOC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_FREE_HEAD;
				state_d    = S_ALLOC_CHK;
			end
			S_ALLOC_CHK: begin
				if (!stat.free_empty) begin
					cmd.alc_w1 = 1'b1;
					state_d    = S_ALLOC_W2;
				end else if (stat.oldest_none) begin
					guard_d = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_OLDEST;
					reclaim_d  = 1'b1;
					state_d    = S_REL_CHK;
				end
			end
			S_ALLOC_W2: begin
				cmd.alc_w2 = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/spa_dp.sv =====
// spa_dp: link memories, list heads, fill count and result register
// depends on spa_pkg; steered by spa_ctrl through cmd_t
`default_nettype none

module spa_dp import spa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SLOT_IO_W-1:0] slot_in,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic [SLOT_IO_W-1:0] slot_out,
	output logic                 reclaimed,
	output logic                 status
);

	// link memories
	logic [LINK_W-1:0] next_mem [SLOTS];
	logic [LINK_W-1:0] prev_mem [SLOTS];
	logic              act_mem  [SLOTS];

	logic [LINK_W-1:0] free_head_q, newest_q, oldest_q;
	logic [LINK_W-1:0] fill_q;

	logic [SLOT_IO_W-1:0] echo_q;
	logic [SLOT_W-1:0]    cur_q;
	logic                 ok_q, written_q;
	logic [LINK_W-1:0]    nxt_rd_q, prv_rd_q;
	logic                 act_rd_q;

	logic [SLOT_IO_W-1:0] slot_out_q;
	logic                 reclaimed_q, status_q;

	logic [SLOT_W-1:0] rd_addr;
	logic              rd_in_pool, rd_written;
	logic [LINK_W-1:0] nxt_eff;

	logic              nx_we, pv_we, ac_we;
	logic [SLOT_W-1:0] nx_wa, pv_wa, ac_wa;
	logic [LINK_W-1:0] nx_wd, pv_wd;
	logic              ac_wd;

	always_comb begin
		case (cmd.rd_sel)
			RA_IN_SLOT: begin
				rd_addr    = SLOT_W'(slot_in);
				rd_in_pool = CMP_W'(slot_in) < CMP_W'(SLOTS);
			end
			RA_FREE_HEAD: begin
				rd_addr    = SLOT_W'(free_head_q);
				rd_in_pool = link_valid(free_head_q);
			end
			default: begin
				rd_addr    = SLOT_W'(oldest_q);
				rd_in_pool = link_valid(oldest_q);
			end
		endcase
		// slots at or above the fill count were never written; their links are taken as reset links
		rd_written = LINK_W'(rd_addr) < fill_q;
	end

	assign nxt_eff = written_q ? nxt_rd_q : (LINK_W'(cur_q) + LINK_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			nxt_rd_q  <= next_mem[rd_addr];
			prv_rd_q  <= prev_mem[rd_addr];
			act_rd_q  <= act_mem[rd_addr];
			cur_q     <= rd_addr;
			ok_q      <= rd_in_pool & rd_written;
			written_q <= rd_written;
		end
		if (cmd.accept) begin
			echo_q <= slot_in;
		end
	end

	// one write per memory and cycle
	always_comb begin
		nx_we = 1'b0;
		nx_wa = cur_q;
		nx_wd = NONE_LINK;
		pv_we = 1'b0;
		pv_wa = cur_q;
		pv_wd = NONE_LINK;
		ac_we = 1'b0;
		ac_wa = cur_q;
		ac_wd = 1'b0;
		if (cmd.rel_w1) begin
			if (link_valid(prv_rd_q)) begin
				nx_we = 1'b1;
				nx_wa = SLOT_W'(prv_rd_q);
				nx_wd = nxt_rd_q;
			end
			if (link_valid(nxt_rd_q)) begin
				pv_we = 1'b1;
				pv_wa = SLOT_W'(nxt_rd_q);
				pv_wd = prv_rd_q;
			end
		end
		if (cmd.rel_w2) begin
			nx_we = 1'b1;
			nx_wd = free_head_q;
			pv_we = 1'b1;
			ac_we = 1'b1;
			ac_wd = 1'b0;
		end
		if (cmd.alc_w1) begin
			nx_we = 1'b1;
			nx_wd = newest_q;
			ac_we = 1'b1;
			ac_wd = 1'b1;
			if (link_valid(newest_q)) begin
				pv_we = 1'b1;
				pv_wa = SLOT_W'(newest_q);
				pv_wd = LINK_W'(cur_q);
			end
		end
		if (cmd.alc_w2) begin
			pv_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (ac_we) begin
			act_mem[ac_wa] <= ac_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			newest_q    <= NONE_LINK;
			oldest_q    <= NONE_LINK;
			fill_q      <= '0;
		end else begin
			if (cmd.rel_w1) begin
				if (!link_valid(prv_rd_q)) begin
					newest_q <= nxt_rd_q;
				end
				if (!link_valid(nxt_rd_q)) begin
					oldest_q <= prv_rd_q;
				end
			end
			if (cmd.rel_w2) begin
				free_head_q <= LINK_W'(cur_q);
			end
			if (cmd.alc_w1) begin
				free_head_q <= nxt_eff;
				if (!link_valid(newest_q)) begin
					oldest_q <= LINK_W'(cur_q);
				end
				if (!written_q) begin
					fill_q <= fill_q + LINK_W'(1);
				end
			end
			if (cmd.alc_w2) begin
				newest_q <= LINK_W'(cur_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.res_guard) begin
				slot_out_q <= '0;
			end else if (cmd.res_echo) begin
				slot_out_q <= echo_q;
			end else begin
				slot_out_q <= SLOT_IO_W'(cur_q);
			end
			reclaimed_q <= cmd.res_reclaimed;
			status_q    <= cmd.res_status;
		end
	end

	assign stat.rd_active   = ok_q & act_rd_q;
	assign stat.free_empty  = !link_valid(free_head_q);
	assign stat.oldest_none = !link_valid(oldest_q);

	assign slot_out  = slot_out_q;
	assign reclaimed = reclaimed_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/slot_pool_allocator_evict_oldest.sv =====
// slot_pool_allocator_evict_oldest: top level of the slot pool allocator
// depends on spa_pkg, spa_ctrl and spa_dp
//
// channel  dir  signals                         word contents
// s        in   s_tvalid s_tready s_tdata s_tuser  slot_in in tdata, func in tuser
// m        out  m_tvalid m_tready m_tdata m_tuser  slot_out in tdata, flags in tuser
//
// one word in flight at a time; a free runs REL_CHK, REL_W2 and DONE (REL_CHK straight
// to DONE when the slot is not active), an allocate ALLOC_CHK, ALLOC_W2 and DONE, and an
// allocate that reclaims the oldest active slot runs REL_CHK, REL_W2, ALLOC_RD in between
// the steps follow from the single write port and registered read of each link memory
// reset is immediate: a fill count stands in for the reset links of untouched slots
// a result waits in the output register, so the next word is taken while m stalls
`default_nettype none

module slot_pool_allocator_evict_oldest import spa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // [8:0] slot_in, rest zero
	input  logic                 s_tuser,   // [0] func
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // [8:0] slot_out, rest zero
	output logic [TUSER_M_W-1:0] m_tuser    // [0] reclaimed, [1] status
);

	cmd_t                 cmd;
	stat_t                stat;
	logic [SLOT_IO_W-1:0] slot_out;
	logic                 reclaimed;
	logic                 status;

	// sequencer
	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// lists, link memories and result register
	spa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.slot_in   (s_tdata[SLOT_IO_W-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.slot_out  (slot_out),
		.reclaimed (reclaimed),
		.status    (status)
	);

	// pad the slot number up to whole bytes
	assign m_tdata = TDATA_W'(slot_out);
	assign m_tuser = {status, reclaimed};

endmodule

`default_nettype wire

// ===== rtl/core/spa_chk.sv =====
// spa_chk: port-level checks of the slot pool allocator
// depends on spa_pkg; bound to slot_pool_allocator_evict_oldest
`default_nettype none

module spa_chk import spa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TDATA_W-1:0]   m_tdata,
	input logic [TUSER_M_W-1:0] m_tuser
);

	// a held result keeps its valid
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a held result keeps its payload
	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// only one word is worked on at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while busy");

	// a reclaim and an error never come together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("reclaimed and error flagged together");

	// padding bits of the result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> SLOT_IO_W) == '0)
		else $error("nonzero padding in result word");

endmodule

bind slot_pool_allocator_evict_oldest spa_chk u_spa_chk (.*);

`default_nettype wire

// ===== bench/tb_slot_pool_allocator_evict_oldest.sv =====
`timescale 1ns / 1ps
// tb_slot_pool_allocator_evict_oldest: self-checking bench for the slot pool allocator
// depends on spa_pkg and slot_pool_allocator_evict_oldest; shadow pool model, random stalls
module tb_slot_pool_allocator_evict_oldest;
	import spa_pkg::*;

	// one request word: func rides in tuser, slot number in tdata
	typedef struct packed {
		logic                 func;
		logic [SLOT_IO_W-1:0] slot;
	} pool_req_t;

	// one answer word as the block should return it
	typedef struct packed {
		logic [SLOT_IO_W-1:0] slot;
		logic                 reclaimed;
		logic                 status;
	} grant_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata  = '0;
	logic                 s_tuser  = FUNC_ALLOC;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [TUSER_M_W-1:0] m_tuser;

	slot_pool_allocator_evict_oldest DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow copy of the pool: free list is lifo, active list runs newest to oldest
	logic [LINK_W-1:0] next_lk [SLOTS];
	logic [LINK_W-1:0] prev_lk [SLOTS];
	logic              act_mk  [SLOTS];
	logic [LINK_W-1:0] free_hd;
	logic [LINK_W-1:0] newest;
	logic [LINK_W-1:0] oldest;

	pool_req_t op_q[$];      // request words not yet put on the bus
	grant_t    answer_q[$];  // answers owed by the block, oldest first

	int n_active   = 0;
	int n_alloc    = 0;
	int n_free     = 0;
	int n_inactive = 0;
	int n_reclaim  = 0;
	int n_checked  = 0;
	int errors     = 0;
	int cyc        = 0;
	logic calm;

	// a stretch of the run where neither side idles at random
	assign calm = (cyc >= 3000) && (cyc < 6000);

	// unlink an active slot and push it on the free list
	function automatic void pool_release(input logic [LINK_W-1:0] s);
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		p = prev_lk[s];
		n = next_lk[s];
		if (p != NONE_LINK) begin
			next_lk[p] = n;
		end else begin
			newest = n;
		end
		if (n != NONE_LINK) begin
			prev_lk[n] = p;
		end else begin
			oldest = p;
		end
		next_lk[s] = free_hd;
		prev_lk[s] = NONE_LINK;
		act_mk[s]  = 1'b0;
		free_hd    = s;
		n_active--;
	endfunction

	// apply one request word to the shadow pool and return the answer it owes
	function automatic grant_t pool_step(input pool_req_t req);
		grant_t            g;
		logic [LINK_W-1:0] s;
		g = '0;
		if (req.func == FUNC_FREE) begin
			n_free++;
			g.slot = req.slot;
			if (req.slot < SLOTS && act_mk[req.slot]) begin
				pool_release(LINK_W'(req.slot));
				g.status = STATUS_OK;
			end else begin
				// double free or never handed out: state untouched
				g.status = STATUS_INACTIVE;
				n_inactive++;
			end
			return g;
		end
		n_alloc++;
		if (free_hd == NONE_LINK) begin
			// pool exhausted: evict the oldest active slot first
			if (oldest == NONE_LINK) begin
				return g;
			end
			pool_release(oldest);
			g.reclaimed = 1'b1;
			n_reclaim++;
		end
		s       = free_hd;
		free_hd = next_lk[s];
		next_lk[s] = newest;
		prev_lk[s] = NONE_LINK;
		if (newest != NONE_LINK) begin
			prev_lk[newest] = s;
		end else begin
			oldest = s;
		end
		newest    = s;
		act_mk[s] = 1'b1;
		n_active++;
		g.slot = s[SLOT_IO_W-1:0];
		return g;
	endfunction

	// random request words with a given allocate share; frees mostly hit live slots
	task automatic run_phase(input int count, input int alloc_pct, input int reclaim_goal);
		pool_req_t r;
		int        k;
		int        idx;
		for (k = 0; k < count && n_reclaim < reclaim_goal; k++) begin
			// short lookahead so live-slot picks track the shadow pool
			while (op_q.size() >= 2) @(posedge clk);
			r.slot = SLOT_IO_W'($urandom_range((1 << SLOT_IO_W) - 1));
			if ($urandom_range(99) < alloc_pct) begin
				r.func = FUNC_ALLOC;
			end else begin
				r.func = FUNC_FREE;
				// now and then a stray slot number, otherwise the next live slot
				if (n_active > 0 && $urandom_range(99) < 85) begin
					idx = int'(r.slot);
					while (!act_mk[idx % SLOTS]) idx++;
					r.slot = SLOT_IO_W'(idx % SLOTS);
				end
			end
			op_q.push_back(r);
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// driver: a word is taken at an edge with tvalid and tready both high;
	// the shadow pool advances right there, so answers queue in accept order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= FUNC_ALLOC;
		end else begin
			if (s_tvalid && s_tready) begin
				answer_q.push_back(pool_step(pool_req_t'{s_tuser, s_tdata[SLOT_IO_W-1:0]}));
			end
			// load a new word once the bus is empty or the last one went through
			if (!s_tvalid || s_tready) begin
				if (op_q.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= TDATA_W'(op_q[0].slot);
					s_tuser  <= op_q[0].func;
					void'(op_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: each answer word is checked field by field against the oldest owed one
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, got slot %0d flags %b",
						$time, m_tdata[SLOT_IO_W-1:0], m_tuser);
				end else begin
					want = answer_q.pop_front();
					n_checked++;
					if (m_tdata[SLOT_IO_W-1:0] !== want.slot) begin
						errors++;
						$display("%0t: slot_out mismatch, expected %0d, got %0d",
							$time, want.slot, m_tdata[SLOT_IO_W-1:0]);
					end
					if (m_tdata[TDATA_W-1:SLOT_IO_W] !== '0) begin
						errors++;
						$display("%0t: tdata pad mismatch, expected 0, got %h",
							$time, m_tdata[TDATA_W-1:SLOT_IO_W]);
					end
					if (m_tuser[0] !== want.reclaimed) begin
						errors++;
						$display("%0t: reclaimed mismatch, expected %b, got %b",
							$time, want.reclaimed, m_tuser[0]);
					end
					if (m_tuser[1] !== want.status) begin
						errors++;
						$display("%0t: status mismatch, expected %b, got %b",
							$time, want.status, m_tuser[1]);
					end
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int i;
		// shadow pool after reset: every slot free in ascending order, nothing active
		for (i = 0; i < SLOTS; i++) begin
			next_lk[i] = LINK_W'(i + 1);
			prev_lk[i] = NONE_LINK;
			act_mk[i]  = 1'b0;
		end
		free_hd = '0;
		newest  = NONE_LINK;
		oldest  = NONE_LINK;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: frees on an empty pool, unlink from middle, head and tail,
		// double free, lifo reuse, then drain back to empty
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd0});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd511});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd511});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd0});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd170});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd341});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd1});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd3});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd0});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd0});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd511});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd0});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd0});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd0});
		op_q.push_back(pool_req_t'{FUNC_ALLOC, 9'd0});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd2});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd4});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd1});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd3});
		op_q.push_back(pool_req_t'{FUNC_FREE,  9'd0});

		// fill the pool until eviction of the oldest slot has happened a good while
		run_phase(1500, 95, 60);
		// churn around the full mark, then drain, then refill part way
		run_phase(400, 50, 32'h7fffffff);
		run_phase(450, 12, 32'h7fffffff);
		run_phase(350, 70, 32'h7fffffff);

		// every word accepted and every owed answer back
		while (op_q.size() != 0 || s_tvalid || answer_q.size() != 0) @(posedge clk);
		// grace period for stray words
		repeat (20) @(posedge clk);

		$display("run: %0d words checked, %0d allocates (%0d with eviction), %0d frees",
			n_checked, n_alloc, n_reclaim, n_free);
		$display("run: %0d frees of inactive slots, %0d slots live at the end, %0d errors",
			n_inactive, n_active, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
